@@ rtl/rtp_pkg.sv @@
// Shared types and constants of the indexed record table parser.
package rtp_pkg;

  localparam int FUNC_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int STAT_W     = 3;
  localparam int ID_W       = 31;
  localparam int FMT_W      = 8;
  localparam int DIM_W      = 16;
  localparam int ENT_W      = 13;
  localparam int MINSZ_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int WORD_W     = 32;
  // entry count after the plausibility check fits 22 bits
  localparam int CNT_W      = 22;
  localparam int IDX_W      = CNT_W + 4;

  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FN_NEXT   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_START  = 2'd2;

  localparam logic [STAT_W-1:0] ST_ACCEPTED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ENTRY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [STAT_W-1:0] ST_IMPLAUSIBLE = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_HEADER  = 3'd4;
  localparam logic [STAT_W-1:0] ST_FINISHED    = 3'd5;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIM  = 1'd1;

  localparam logic [MINSZ_W-1:0] MIN_SIZE_RST = 8'd32;
  localparam logic [DIM_W-1:0]   MAX_DIM_RST  = 16'd16384;
  localparam logic [WORD_W-1:0]  MAX_COUNT    = 32'd4000000;

  localparam int HDR_BYTES  = 8;
  localparam int COUNT_OFS  = 4;
  localparam int INDEX_OFS  = 8;
  localparam int SIZE_OFS   = 12;
  localparam int ENTRY_B    = 8;
  localparam int REC_FMT    = 12;
  localparam int REC_DIM    = 20;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR,
    S_HDR2,
    S_ID,
    S_SIZE,
    S_SCAN,
    S_FMT,
    S_DIM,
    S_EMIT
  } state_t;

endpackage

@@ rtl/rtp_if.sv @@
// Request and result channel interfaces of the indexed record table parser.
interface rtp_req_if;
  logic                          valid;
  logic                          ready;
  logic [rtp_pkg::FUNC_W-1:0]    func;
  logic [rtp_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface rtp_res_if;
  logic                          valid;
  logic                          ready;
  logic [rtp_pkg::STAT_W-1:0]    status;
  logic [rtp_pkg::ID_W-1:0]      record_id;
  logic [rtp_pkg::FMT_W-1:0]     pixel_format;
  logic [rtp_pkg::DIM_W-1:0]     tex_width;
  logic [rtp_pkg::DIM_W-1:0]     tex_height;
  logic [rtp_pkg::ENT_W-1:0]     entry_number;
  logic [rtp_pkg::ENT_W-1:0]     accepted_total;
  logic                          done_res;

  modport source (output valid, output status, output record_id, output pixel_format,
                  output tex_width, output tex_height, output entry_number,
                  output accepted_total, output done_res, input ready);
  modport sink   (input valid, input status, input record_id, input pixel_format,
                  input tex_width, input tex_height, input entry_number,
                  input accepted_total, input done_res, output ready);
endinterface

@@ rtl/indexed_record_table_parser.sv @@
// Indexed record table parser: blob byte store, index walk and record lookup.
//
// Channels: req carries requests (func, data_byte) with valid/ready; res carries one
// status result per "next" request; cfg_we/cfg_index/cfg_data write the min record
// size (index 0) and the max dimension (index 1).
// Append and start requests leave the sequencer idle, so bytes stream in at one per cycle
// while it is idle into a word-wide store (byte lanes, one read port, registered output).
// A "next" request walks a small sequencer over that read port: header count, index
// id and size, then an aligned word scan at one word per cycle, then the record
// format and width/height words. Only one request is in flight; req.ready is high
// while the sequencer is idle.
// A result waits in the output register while res.ready is low; appends keep being
// accepted meanwhile, and a following "next" request holds its result until the
// output register frees.
// Reset clears the length, flags and counters and loads the config defaults; store
// contents are undefined and need no clearing pass, since only bytes below the length are read.
module indexed_record_table_parser #(
  parameter int BLOB_BYTES = 65536
) (
  input  logic                               clk,
  input  logic                               rst,
  rtp_req_if.sink                            req,
  rtp_res_if.source                          res,
  input  logic                               cfg_we,
  input  logic [rtp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WORDS = (BLOB_BYTES + 3) / 4;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LW    = $clog2(BLOB_BYTES + 1);
  localparam int AB    = LW + 4;
  localparam int CMP_W = (LW > rtp_pkg::IDX_W) ? LW : rtp_pkg::IDX_W;
  localparam int WB    = rtp_pkg::WORD_W / 4;

  rtp_pkg::state_t state, state_next;

  logic [3:0][WB-1:0]            mem [WORDS];
  logic [rtp_pkg::WORD_W-1:0]    mem_q;
  logic                          rd_ok;
  logic                          rd_lo_ok;
  logic [AB-1:0]                 rd_byte;
  logic                          wr_en;

  logic [LW-1:0]                 blob_len;
  logic                          overflow;
  logic [LW-1:0]                 next_entry;
  logic [LW-1:0]                 cursor;
  logic [rtp_pkg::ENT_W-1:0]     acc_cnt;
  logic [rtp_pkg::MINSZ_W-1:0]   min_size;
  logic [rtp_pkg::DIM_W-1:0]     max_dim;

  logic [rtp_pkg::CNT_W-1:0]     count;
  logic [LW-1:0]                 entry_idx;
  logic [rtp_pkg::WORD_W-1:0]    sno;
  logic [LW-1:0]                 scan_addr;
  logic                          pend;
  logic [LW-1:0]                 pend_addr;
  logic [rtp_pkg::FMT_W-1:0]     fmt;
  logic                          fmt_big;

  logic [rtp_pkg::STAT_W-1:0]    res_status;
  logic [rtp_pkg::ID_W-1:0]      res_id;
  logic [rtp_pkg::FMT_W-1:0]     res_fmt;
  logic [rtp_pkg::DIM_W-1:0]     res_w;
  logic [rtp_pkg::DIM_W-1:0]     res_h;
  logic [rtp_pkg::ENT_W-1:0]     res_ent;

  logic                          out_valid;
  logic [rtp_pkg::STAT_W-1:0]    out_status;
  logic [rtp_pkg::ID_W-1:0]      out_id;
  logic [rtp_pkg::FMT_W-1:0]     out_fmt;
  logic [rtp_pkg::DIM_W-1:0]     out_w;
  logic [rtp_pkg::DIM_W-1:0]     out_h;
  logic [rtp_pkg::ENT_W-1:0]     out_ent;
  logic [rtp_pkg::ENT_W-1:0]     out_total;
  logic                          out_done;

  logic                          accept;
  logic                          room;
  logic                          hdr_early;
  logic [rtp_pkg::WORD_W-1:0]    word_q;
  logic                          count_bad;
  logic [rtp_pkg::IDX_W-1:0]     idx_end;
  logic                          idx_short;
  logic                          finished;
  logic                          bad_entry;
  logic [LW:0]                   scan_lim;
  logic                          scan_ok;
  logic                          hit;
  logic [rtp_pkg::DIM_W-1:0]     dim_w;
  logic [rtp_pkg::DIM_W-1:0]     dim_h;
  logic                          implausible;
  logic                          out_free;

  assign req.ready = (state == rtp_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign room      = blob_len < LW'(BLOB_BYTES);
  assign wr_en     = accept && (req.func == rtp_pkg::FN_APPEND) && room;
  assign hdr_early = overflow || (blob_len < LW'(rtp_pkg::HDR_BYTES));

  // words that reach past the loaded length read as zero
  assign word_q    = rd_ok ? mem_q : '0;
  assign count_bad = (word_q == '0) || (word_q > rtp_pkg::MAX_COUNT);
  assign idx_end   = rtp_pkg::IDX_W'({count, 3'b000}) + rtp_pkg::IDX_W'(rtp_pkg::INDEX_OFS);
  assign idx_short = CMP_W'(idx_end) > CMP_W'(blob_len);
  assign finished  = CMP_W'(next_entry) >= CMP_W'(count);
  assign bad_entry = (sno == '0) || sno[31] || word_q[31] ||
                     (word_q < rtp_pkg::WORD_W'(min_size));
  assign scan_lim  = (LW+1)'(scan_addr) + (LW+1)'(min_size);
  assign scan_ok   = scan_lim <= (LW+1)'(blob_len);
  assign hit       = pend && (word_q == sno);
  // the width half can be loaded while the height half is not
  assign dim_w     = rd_lo_ok ? mem_q[rtp_pkg::DIM_W-1:0] : '0;
  assign dim_h     = word_q[2*rtp_pkg::DIM_W-1:rtp_pkg::DIM_W];
  assign implausible = (dim_w == '0) || (dim_h == '0) || (dim_w > max_dim) ||
                       (dim_h > max_dim) || fmt_big;
  assign out_free  = !out_valid || res.ready;

  // byte store: one byte lane written per append, one word read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[blob_len[WAW+1:2]][blob_len[1:0]] <= req.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    mem_q    <= mem[rd_byte[WAW+1:2]];
    rd_ok    <= (rd_byte + AB'(4)) <= AB'(blob_len);
    rd_lo_ok <= (rd_byte + AB'(2)) <= AB'(blob_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rtp_pkg::S_IDLE: begin
        if (accept && (req.func == rtp_pkg::FN_NEXT)) begin
          state_next = hdr_early ? rtp_pkg::S_EMIT : rtp_pkg::S_HDR;
        end
      end
      rtp_pkg::S_HDR:  state_next = count_bad ? rtp_pkg::S_EMIT : rtp_pkg::S_HDR2;
      rtp_pkg::S_HDR2: state_next = (idx_short || finished) ? rtp_pkg::S_EMIT : rtp_pkg::S_ID;
      rtp_pkg::S_ID:   state_next = rtp_pkg::S_SIZE;
      rtp_pkg::S_SIZE: state_next = bad_entry ? rtp_pkg::S_EMIT : rtp_pkg::S_SCAN;
      rtp_pkg::S_SCAN: begin
        if (hit) begin
          state_next = rtp_pkg::S_FMT;
        end else if (!scan_ok) begin
          state_next = rtp_pkg::S_EMIT;
        end
      end
      rtp_pkg::S_FMT:  state_next = rtp_pkg::S_DIM;
      rtp_pkg::S_DIM:  state_next = rtp_pkg::S_EMIT;
      rtp_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = rtp_pkg::S_IDLE;
        end
      end
      default: state_next = rtp_pkg::S_IDLE;
    endcase
  end

  // read address for the word needed in the following state
  always_comb begin
    rd_byte = AB'(rtp_pkg::COUNT_OFS);
    unique case (state)
      rtp_pkg::S_HDR2: rd_byte = AB'({next_entry, 3'b000}) + AB'(rtp_pkg::INDEX_OFS);
      rtp_pkg::S_ID:   rd_byte = AB'({entry_idx, 3'b000}) + AB'(rtp_pkg::SIZE_OFS);
      rtp_pkg::S_SCAN: rd_byte = hit ? AB'(pend_addr) + AB'(rtp_pkg::REC_FMT) : AB'(scan_addr);
      rtp_pkg::S_FMT:  rd_byte = AB'(pend_addr) + AB'(rtp_pkg::REC_DIM);
      default:         rd_byte = AB'(rtp_pkg::COUNT_OFS);
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blob_len   <= '0;
      overflow   <= 1'b0;
      next_entry <= '0;
      cursor     <= '0;
      acc_cnt    <= '0;
      min_size   <= rtp_pkg::MIN_SIZE_RST;
      max_dim    <= rtp_pkg::MAX_DIM_RST;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rtp_pkg::REG_MIN_SIZE: min_size <= cfg_data[rtp_pkg::MINSZ_W-1:0];
          rtp_pkg::REG_MAX_DIM:  max_dim  <= cfg_data;
          default: ;
        endcase
      end

      if (accept && (req.func == rtp_pkg::FN_APPEND)) begin
        if (room) begin
          blob_len <= blob_len + LW'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (accept && (req.func == rtp_pkg::FN_START)) begin
        blob_len   <= '0;
        overflow   <= 1'b0;
        next_entry <= '0;
        cursor     <= '0;
        acc_cnt    <= '0;
      end

      if ((state == rtp_pkg::S_HDR2) && !idx_short && !finished) begin
        next_entry <= next_entry + LW'(1);
        if (CMP_W'(cursor) < CMP_W'(idx_end)) begin
          cursor <= LW'(idx_end);
        end
      end

      if (state == rtp_pkg::S_SIZE) begin
        pend <= 1'b0;
      end
      if (state == rtp_pkg::S_SCAN) begin
        if (hit) begin
          cursor <= pend_addr + LW'(4);
        end else if (scan_ok) begin
          pend <= 1'b1;
        end
      end

      if ((state == rtp_pkg::S_DIM) && !implausible) begin
        acc_cnt <= acc_cnt + rtp_pkg::ENT_W'(1);
      end

      if ((state == rtp_pkg::S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      rtp_pkg::S_IDLE: begin
        res_status <= overflow ? rtp_pkg::ST_TOO_LARGE : rtp_pkg::ST_BAD_HEADER;
        res_id     <= '0;
        res_fmt    <= '0;
        res_w      <= '0;
        res_h      <= '0;
        res_ent    <= '0;
      end
      rtp_pkg::S_HDR: begin
        count <= word_q[rtp_pkg::CNT_W-1:0];
      end
      rtp_pkg::S_HDR2: begin
        entry_idx <= next_entry;
        if (idx_short) begin
          res_status <= rtp_pkg::ST_BAD_HEADER;
        end else if (finished) begin
          res_status <= rtp_pkg::ST_FINISHED;
          res_ent    <= rtp_pkg::ENT_W'(next_entry);
        end
      end
      rtp_pkg::S_ID: begin
        sno <= word_q;
      end
      rtp_pkg::S_SIZE: begin
        scan_addr  <= cursor;
        res_status <= rtp_pkg::ST_BAD_ENTRY;
        res_id     <= sno[rtp_pkg::ID_W-1:0];
        res_ent    <= rtp_pkg::ENT_W'(entry_idx);
      end
      rtp_pkg::S_SCAN: begin
        res_status <= rtp_pkg::ST_NOT_FOUND;
        if (!hit && scan_ok) begin
          pend_addr <= scan_addr;
          scan_addr <= scan_addr + LW'(4);
        end
      end
      rtp_pkg::S_FMT: begin
        fmt     <= word_q[rtp_pkg::FMT_W-1:0];
        fmt_big <= |word_q[rtp_pkg::WORD_W-1:rtp_pkg::FMT_W];
      end
      rtp_pkg::S_DIM: begin
        res_w      <= dim_w;
        res_h      <= dim_h;
        res_status <= implausible ? rtp_pkg::ST_IMPLAUSIBLE : rtp_pkg::ST_ACCEPTED;
        res_fmt    <= implausible ? '0 : fmt;
      end
      rtp_pkg::S_EMIT: begin
        if (out_free) begin
          out_status <= res_status;
          out_id     <= res_id;
          out_fmt    <= res_fmt;
          out_w      <= res_w;
          out_h      <= res_h;
          out_ent    <= res_ent;
          out_total  <= acc_cnt;
          out_done   <= (res_status == rtp_pkg::ST_BAD_HEADER) ||
                        (res_status == rtp_pkg::ST_FINISHED) ||
                        (res_status == rtp_pkg::ST_TOO_LARGE);
        end
      end
      default: ;
    endcase
  end

  assign res.valid          = out_valid;
  assign res.status         = out_status;
  assign res.record_id      = out_id;
  assign res.pixel_format   = out_fmt;
  assign res.tex_width      = out_w;
  assign res.tex_height     = out_h;
  assign res.entry_number   = out_ent;
  assign res.accepted_total = out_total;
  assign res.done_res       = out_done;

endmodule
